// File: sv/msfp_pkg.sv
// ----------------------------------------------------------------------------
// msfp_pkg
// Shared types and constants for the motor speed frame parser.
// ----------------------------------------------------------------------------
package msfp_pkg;

  localparam int unsigned MAX_DIGITS_DEF = 7;
  localparam int unsigned NUM_VALUES_DEF = 4;

  localparam int unsigned SPEED_W = 16;
  localparam int unsigned NUM_OUT = 4;
  localparam int unsigned OUT_W   = SPEED_W * NUM_OUT;

  localparam int unsigned QUEUE_AW    = 1;
  localparam int unsigned QUEUE_DEPTH = 2 ** QUEUE_AW;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [3:0] {
    TK_DOLLAR,
    TK_M,
    TK_S,
    TK_P,
    TK_D,
    TK_COLON,
    TK_HASH,
    TK_COMMA,
    TK_MINUS,
    TK_DIGIT,
    TK_OTHER
  } tok_e;

  typedef struct packed {
    tok_e       kind;
    logic [3:0] digit;
  } token_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DOLLAR,
    PH_M,
    PH_S,
    PH_P,
    PH_D,
    PH_DATA
  } phase_e;

endpackage

// File: sv/msfp_front.sv
// ----------------------------------------------------------------------------
// msfp_front
// Accepts received bytes and classifies each into a parser token.
// ----------------------------------------------------------------------------
module msfp_front (
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,
  input  logic            full_i,
  output logic            push_o,
  output msfp_pkg::token_t tok_o
);
  import msfp_pkg::*;

  assign s_axis_tready = ~full_i;
  assign push_o        = s_axis_tvalid & ~full_i;

  always_comb begin
    tok_o.digit = s_axis_tdata[3:0];
    if (s_axis_tdata inside {[CH_ZERO:CH_NINE]}) begin
      tok_o.kind = TK_DIGIT;
    end else begin
      case (s_axis_tdata)
        CH_DOLLAR: tok_o.kind = TK_DOLLAR;
        CH_M:      tok_o.kind = TK_M;
        CH_S:      tok_o.kind = TK_S;
        CH_P:      tok_o.kind = TK_P;
        CH_D:      tok_o.kind = TK_D;
        CH_COLON:  tok_o.kind = TK_COLON;
        CH_HASH:   tok_o.kind = TK_HASH;
        CH_COMMA:  tok_o.kind = TK_COMMA;
        CH_MINUS:  tok_o.kind = TK_MINUS;
        default:   tok_o.kind = TK_OTHER;
      endcase
    end
  end

endmodule

// File: sv/msfp_queue.sv
// ----------------------------------------------------------------------------
// msfp_queue
// Short token queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module msfp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  msfp_pkg::token_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output msfp_pkg::token_t data_o
);
  import msfp_pkg::*;

  token_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: sv/msfp_back.sv
// ----------------------------------------------------------------------------
// msfp_back
// Frame parser: header tracking, decimal accumulation, value slots and the
// registered result output.
// ----------------------------------------------------------------------------
module msfp_back #(
  parameter int unsigned MAX_DIGITS = msfp_pkg::MAX_DIGITS_DEF,
  parameter int unsigned NUM_VALUES = msfp_pkg::NUM_VALUES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  msfp_pkg::token_t             tok_i,
  output logic                         pop_o,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [msfp_pkg::OUT_W-1:0]   m_axis_tdata
);
  import msfp_pkg::*;

  localparam int unsigned SLOT_W = $clog2(NUM_VALUES + 1);
  localparam int unsigned DCNT_W = (MAX_DIGITS < 2) ? 1 : $clog2(MAX_DIGITS + 1);
  localparam int unsigned SLOT_N = (NUM_VALUES > NUM_OUT) ? NUM_VALUES : NUM_OUT;

  phase_e              phase_q, phase_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [DCNT_W-1:0]   dcnt_q, dcnt_d;
  logic [SPEED_W-1:0]  acc_q, acc_d;
  logic                neg_q, neg_d;
  logic [SPEED_W-1:0]  slots_q [SLOT_N];
  logic [SPEED_W-1:0]  slots_d [SLOT_N];
  logic                out_valid_q, out_valid_d;
  logic [OUT_W-1:0]    out_data_q, out_data_d;

  logic                in_data;
  logic                hash_hit;
  logic                store;
  logic [SPEED_W-1:0]  pending;

  // only a frame end needs the output register free
  assign hash_hit      = (phase_q == PH_DATA) & (tok_i.kind == TK_HASH);
  assign pop_o         = valid_i & (~hash_hit | ~out_valid_q | m_axis_tready);
  assign in_data       = pop_o & (phase_q == PH_DATA);
  assign pending       = neg_q ? (SPEED_W'(0) - acc_q) : acc_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (pop_o) begin
      case (phase_q)
        PH_IDLE:   phase_d = (tok_i.kind == TK_DOLLAR) ? PH_DOLLAR : PH_IDLE;
        PH_DOLLAR: phase_d = (tok_i.kind == TK_M)      ? PH_M      : PH_IDLE;
        PH_M:      phase_d = (tok_i.kind == TK_S)      ? PH_S      : PH_IDLE;
        PH_S:      phase_d = (tok_i.kind == TK_P)      ? PH_P      : PH_IDLE;
        PH_P:      phase_d = (tok_i.kind == TK_D)      ? PH_D      : PH_IDLE;
        PH_D:      phase_d = (tok_i.kind == TK_COLON)  ? PH_DATA   : PH_IDLE;
        PH_DATA:   phase_d = (tok_i.kind == TK_HASH)   ? PH_IDLE   : PH_DATA;
        default:   phase_d = PH_IDLE;
      endcase
    end
  end

  // value section datapath
  always_comb begin
    slot_d      = slot_q;
    dcnt_d      = dcnt_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    store       = 1'b0;
    out_valid_d = out_valid_q & ~m_axis_tready;

    if (in_data) begin
      case (tok_i.kind)
        TK_HASH: begin
          store  = (slot_q == SLOT_W'(NUM_VALUES - 1)) && (dcnt_q != '0);
          slot_d = '0;
          dcnt_d = '0;
          acc_d  = '0;
          neg_d  = 1'b0;
          out_valid_d = 1'b1;
        end
        TK_COMMA: begin
          if (slot_q < SLOT_W'(NUM_VALUES)) begin
            if (dcnt_q != '0) begin
              store  = 1'b1;
              slot_d = slot_q + SLOT_W'(1);
            end
            dcnt_d = '0;
            acc_d  = '0;
            neg_d  = 1'b0;
          end
        end
        TK_MINUS: neg_d = 1'b1;
        TK_DIGIT: begin
          if (dcnt_q < DCNT_W'(MAX_DIGITS)) begin
            acc_d  = (acc_q << 3) + (acc_q << 1) + SPEED_W'(tok_i.digit);
            dcnt_d = dcnt_q + DCNT_W'(1);
          end
        end
        default: ;
      endcase
    end

    for (int k = 0; k < SLOT_N; k++) begin
      slots_d[k] = slots_q[k];
      if (store && (k < NUM_VALUES) && (32'(slot_q) == k)) begin
        slots_d[k] = pending;
      end
    end

    out_data_d = out_data_q;
    if (in_data && (tok_i.kind == TK_HASH)) begin
      for (int k = 0; k < NUM_OUT; k++) begin
        out_data_d[k*SPEED_W +: SPEED_W] = slots_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      slot_q      <= '0;
      dcnt_q      <= '0;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < SLOT_N; k++) begin
        slots_q[k] <= '0;
      end
    end else begin
      phase_q     <= phase_d;
      slot_q      <= slot_d;
      dcnt_q      <= dcnt_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
      for (int k = 0; k < SLOT_N; k++) begin
        slots_q[k] <= slots_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

// File: sv/motor_speed_frame_parser.sv
// ----------------------------------------------------------------------------
// motor_speed_frame_parser
// Parses ASCII frames "$MSPD:a,b,c,d#" from a byte stream into four speeds.
//
// Input channel s_axis: one received byte per transfer.
// Output channel m_axis: one transfer per completed frame, carrying the four
// stored speed values (16-bit two's complement each).
// A classifier takes one byte per cycle while the two-entry token queue is
// not full; the parser drains one token per cycle unless a '#' waits for the
// output. Sustained rate: one byte per cycle while m_axis does not stall.
// The result is registered when the parser pops the '#' token from the queue.
// When m_axis stalls with a result pending, the parser keeps taking bytes;
// only a later '#' waits for the output, and s_axis_tready drops once one
// more byte is queued behind it.
// Reset clears the queue, the parser state and all value slots to zero.
// ----------------------------------------------------------------------------
module motor_speed_frame_parser #(
  parameter int unsigned MAX_DIGITS = msfp_pkg::MAX_DIGITS_DEF,
  parameter int unsigned NUM_VALUES = msfp_pkg::NUM_VALUES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] rx_byte
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [15:0] speed_one, [31:16] speed_two, [47:32] speed_three,
  // [63:48] speed_four
  output logic [msfp_pkg::OUT_W-1:0] m_axis_tdata
);
  import msfp_pkg::*;

  logic   push;
  logic   full;
  logic   pop;
  logic   q_valid;
  token_t tok_in;
  token_t tok_out;

  msfp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .full_i        (full),
    .push_o        (push),
    .tok_o         (tok_in)
  );

  msfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (tok_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (tok_out)
  );

  msfp_back #(
    .MAX_DIGITS (MAX_DIGITS),
    .NUM_VALUES (NUM_VALUES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .tok_i         (tok_out),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: test/tb_motor_speed_frame_parser.sv
// ----------------------------------------------------------------------------
// tb_motor_speed_frame_parser
// Feeds bytes into the frame parser: a directed part with header breaks,
// long digit runs, empty values, surplus commas, short frames and stray
// bytes, then mostly well-formed random frames mixed with noise. A
// scoreboard predicts the four speeds of each completed frame and checks
// every output transfer. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_motor_speed_frame_parser;
  import msfp_pkg::*;

  localparam int unsigned DIGIT_LIMIT = MAX_DIGITS_DEF;
  localparam int unsigned SLOT_COUNT  = NUM_VALUES_DEF;
  localparam int unsigned RANDOM_BYTES = 1600;

  // packed from the top: speed_four sits in the high bits
  typedef struct packed {
    logic [15:0] four;
    logic [15:0] three;
    logic [15:0] two;
    logic [15:0] one;
  } speed_frame_t;

  class speed_frame_board;
    phase_e       phase;
    int unsigned  slot_idx;
    int unsigned  digits;
    logic [23:0]  magnitude;
    logic         minus;
    logic [15:0]  slots[4];
    speed_frame_t frames_due[$];
    int unsigned  errors;

    function new();
      phase    = PH_IDLE;
      slot_idx = 0;
      clear_pending();
      foreach (slots[k]) slots[k] = '0;
      errors = 0;
    endfunction

    function void clear_pending();
      digits    = 0;
      magnitude = '0;
      minus     = 1'b0;
    endfunction

    function logic [15:0] pending_speed();
      return minus ? (16'd0 - magnitude[15:0]) : magnitude[15:0];
    endfunction

    function void take_byte(logic [7:0] b);
      speed_frame_t f;
      case (phase)
        PH_IDLE:   if (b == CH_DOLLAR) phase = PH_DOLLAR;
        PH_DOLLAR: phase = (b == CH_M) ? PH_M : PH_IDLE;
        PH_M:      phase = (b == CH_S) ? PH_S : PH_IDLE;
        PH_S:      phase = (b == CH_P) ? PH_P : PH_IDLE;
        PH_P:      phase = (b == CH_D) ? PH_D : PH_IDLE;
        PH_D:      phase = (b == CH_COLON) ? PH_DATA : PH_IDLE;
        PH_DATA: begin
          if (b == CH_HASH) begin
            if (slot_idx == SLOT_COUNT - 1 && digits != 0) slots[slot_idx] = pending_speed();
            f.one   = slots[0];
            f.two   = slots[1];
            f.three = slots[2];
            f.four  = slots[3];
            frames_due.push_back(f);
            phase    = PH_IDLE;
            slot_idx = 0;
            clear_pending();
          end else if (b == CH_COMMA) begin
            if (slot_idx < SLOT_COUNT) begin
              if (digits != 0) begin
                slots[slot_idx] = pending_speed();
                slot_idx++;
              end
              clear_pending();
            end
          end else if (b == CH_MINUS) begin
            minus = 1'b1;
          end else if (b >= CH_ZERO && b <= CH_NINE && digits < DIGIT_LIMIT) begin
            magnitude = 24'(magnitude * 24'd10 + 24'(b - CH_ZERO));
            digits++;
          end
        end
        default: phase = PH_IDLE;
      endcase
    endfunction

    function void report(string field, logic [15:0] want, logic [15:0] got);
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %0d, got %0d", field, $signed(want), $signed(got));
    endfunction

    function void check_frame(speed_frame_t got);
      speed_frame_t want;
      if (frames_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("frame %h arrived with none expected", got);
        return;
      end
      want = frames_due.pop_front();
      if (got.one !== want.one)     report("speed_one", want.one, got.one);
      if (got.two !== want.two)     report("speed_two", want.two, got.two);
      if (got.three !== want.three) report("speed_three", want.three, got.three);
      if (got.four !== want.four)   report("speed_four", want.four, got.four);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  speed_frame_board sb = new();
  int unsigned bytes_sent = 0;

  motor_speed_frame_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // quiet stretch: neither side idles
  function automatic bit steady();
    return bytes_sent >= 900 && bytes_sent < 1250;
  endfunction

  always @(negedge clk_i) begin
    m_axis_tready <= steady() ? 1'b1 : ($urandom_range(99) >= 12);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_frame(speed_frame_t'(m_axis_tdata));
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while (!steady() && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.frames_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random_frame();
    logic [7:0] hdr[6];
    logic [7:0] fb[$];
    int unsigned nvals;
    int unsigned ndig;
    int unsigned brk;
    hdr = '{CH_DOLLAR, CH_M, CH_S, CH_P, CH_D, CH_COLON};
    brk = ($urandom_range(99) < 6) ? $urandom_range(5) : 6;
    for (int i = 0; i < 6; i++) fb.push_back(i == brk ? 8'($urandom_range(255)) : hdr[i]);
    nvals = $urandom_range(6);
    for (int v = 0; v < nvals; v++) begin
      if ($urandom_range(99) < 30) fb.push_back(CH_MINUS);
      ndig = ($urandom_range(99) < 85) ? $urandom_range(5) : $urandom_range(9, 6);
      for (int d = 0; d < ndig; d++) begin
        fb.push_back(8'(CH_ZERO + $urandom_range(9)));
        if ($urandom_range(99) < 3) fb.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 5) fb.push_back(CH_MINUS);
      if (v + 1 < nvals) begin
        fb.push_back(CH_COMMA);
        if ($urandom_range(99) < 8) fb.push_back(CH_COMMA);
      end
    end
    if ($urandom_range(99) < 92) fb.push_back(CH_HASH);
    foreach (fb[i]) send_byte(fb[i]);
  endtask

  initial begin
    bit paused;
    paused        = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("$MSX$MSPD:99999999,-,5,-65536,1,2,3#");
    send_text("$MSPD:-32768,32767,0,-1#");
    send_text("$MSPD:7$");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CH_HASH);
    drain();

    while (bytes_sent < RANDOM_BYTES + 60) begin
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
      end else begin
        send_random_frame();
      end
      if (!paused && bytes_sent > 800) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_motor_speed_frame_parser: clean");
    end else begin
      $display("tb_motor_speed_frame_parser: errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_motor_speed_frame_parser: errors");
    $finish;
  end

endmodule

// File: files.f
sv/msfp_pkg.sv
sv/msfp_front.sv
sv/msfp_queue.sv
sv/msfp_back.sv
sv/motor_speed_frame_parser.sv
test/tb_motor_speed_frame_parser.sv
